// ===== design/dual_role_key_tap_detector_defines.svh =====
// Assertion macros used by the RTL of the dual-role key tap detector.
`ifndef DUAL_ROLE_KEY_TAP_DETECTOR_DEFINES_SVH
`define DUAL_ROLE_KEY_TAP_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRKTD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dual_role_key_tap_detector: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DRKTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dual_role_key_tap_detector: assertion failed");

`endif

// ===== design/drktd_pkg.sv =====
package drktd_pkg;

  localparam int KEY_W      = 8;
  localparam int TIME_W     = 32;
  localparam int TIMEOUT_W  = 16;
  localparam int HELD_W     = 9;
  localparam int IN_TDATA_W = 56;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd600;

  typedef enum logic [1:0] {
    FUNC_PRESS     = 2'd0,
    FUNC_RELEASE   = 2'd1,
    FUNC_POINTER   = 2'd2,
    FUNC_MAP_WRITE = 2'd3
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [KEY_W-1:0]  key_code;
    logic [TIME_W-1:0] time_ms;
    logic [KEY_W-1:0]  art_code;
    logic              art_valid;
  } item_t;

  typedef struct packed {
    logic emit;
    logic pt_we;
    logic map_we;
  } ctl_t;

  typedef struct packed {
    logic             load;
    logic [KEY_W-1:0] code;
  } pair_t;

endpackage

// ===== design/dual_role_key_tap_detector.sv =====
// Channel   Direction  Transfer when          Payload
// in_       slave      in_tvalid & in_tready  tuser: func; tdata: key, time, art code, art valid
// out_      master     out_tvalid & out_tready tdata: key code; tuser: pressed; tlast: release
// cfg_      slave      cfg_valid & cfg_ready  cfg_data: tap timeout in ms (always ready)
//
// An item waits in the input register, where the map code and press time memories deliver
// their registered reads, and updates all key state as it leaves that register.
// A new item is accepted every cycle unless an item is held; a tap needs two output transfers,
// so a tapping item waits in the input register until the output register can take the pair.
// Reset is synchronous and clears all flags, the held count and the timeout to 600 ms.
module dual_role_key_tap_detector #(
  parameter int NUM_CODES = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [7:0] key_code, [39:8] time_ms, [47:40] art_code, [48] art_valid, [55:49] zero
  input  logic [drktd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [1:0] func
  input  logic [1:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [7:0] out_key_code
  output logic [drktd_pkg::KEY_W-1:0]           out_tdata,
  // [0] out_pressed
  output logic                                  out_tuser,
  output logic                                  out_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [drktd_pkg::TIMEOUT_W-1:0]       cfg_data
);
  import drktd_pkg::*;
  `include "dual_role_key_tap_detector_defines.svh"

  localparam int IDX_W = $clog2(NUM_CODES);

  logic [TIMEOUT_W-1:0] timeout_r;
  logic                 s1_valid_r;
  item_t                s1_item_r;
  item_t                in_item;
  logic                 accept;
  logic                 proceed;
  logic                 out_free;
  ctl_t                 ctl;
  pair_t                pair;
  logic [IDX_W-1:0]     in_idx;
  logic [IDX_W-1:0]     s1_idx;
  logic [TIME_W-1:0]    pt_rdata;
  logic [KEY_W-1:0]     code_rdata;
  logic [TIME_W-1:0]    pt_eff;
  logic [KEY_W-1:0]     code_eff;
  logic                 pt_we;
  logic                 map_we;
  logic                 fwd_pt_hit_r;
  logic [TIME_W-1:0]    fwd_pt_r;
  logic                 fwd_code_hit_r;
  logic [KEY_W-1:0]     fwd_code_r;
  logic [NUM_CODES-1:0] key_down;
  logic [HELD_W-1:0]    held_count;

  assign in_item.func      = func_t'(in_tuser);
  assign in_item.key_code  = in_tdata[7:0];
  assign in_item.time_ms   = in_tdata[39:8];
  assign in_item.art_code  = in_tdata[47:40];
  assign in_item.art_valid = in_tdata[48];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_r <= cfg_data;
    end
  end

  assign proceed   = s1_valid_r && (!ctl.emit || out_free);
  assign in_tready = !s1_valid_r || proceed;
  assign accept    = in_tvalid && in_tready;
  assign in_idx    = in_item.key_code[IDX_W-1:0];
  assign s1_idx    = s1_item_r.key_code[IDX_W-1:0];
  assign pt_we     = proceed && ctl.pt_we;
  assign map_we    = proceed && ctl.map_we;
  assign pt_eff    = fwd_pt_hit_r ? fwd_pt_r : pt_rdata;
  assign code_eff  = fwd_code_hit_r ? fwd_code_r : code_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      fwd_pt_hit_r   <= 1'b0;
      fwd_code_hit_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r     <= 1'b1;
      fwd_pt_hit_r   <= pt_we && (s1_idx == in_idx);
      fwd_code_hit_r <= map_we && (s1_idx == in_idx);
    end else if (proceed) begin
      s1_valid_r <= 1'b0;
    end
    if (accept) begin
      s1_item_r  <= in_item;
      fwd_pt_r   <= s1_item_r.time_ms;
      fwd_code_r <= s1_item_r.art_code;
    end
  end

  drktd_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_CODES)
  ) u_press_time (
    .clk   (clk),
    .we    (pt_we),
    .waddr (s1_idx),
    .wdata (s1_item_r.time_ms),
    .re    (accept),
    .raddr (in_idx),
    .rdata (pt_rdata)
  );

  drktd_ram #(
    .WIDTH (KEY_W),
    .DEPTH (NUM_CODES)
  ) u_map_code (
    .clk   (clk),
    .we    (map_we),
    .waddr (s1_idx),
    .wdata (s1_item_r.art_code),
    .re    (accept),
    .raddr (in_idx),
    .rdata (code_rdata)
  );

  drktd_keystate #(
    .NUM_CODES (NUM_CODES)
  ) u_keystate (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (proceed),
    .item       (s1_item_r),
    .press_time (pt_eff),
    .timeout    (timeout_r),
    .ctl        (ctl),
    .key_down   (key_down),
    .held_count (held_count)
  );

  assign pair.load = proceed && ctl.emit;
  assign pair.code = code_eff;

  drktd_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .pair       (pair),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `DRKTD_ASSERT_NOW(a_held_matches_down, clk, rst_n, 1'b1,
    HELD_W'($countones(key_down)) == held_count)
  `DRKTD_ASSERT_NEXT(a_release_follows_press, clk, rst_n,
    out_tvalid && out_tready && out_tuser,
    out_tvalid && !out_tuser && $stable(out_tdata))
  `DRKTD_ASSERT_NOW(a_pair_starts_with_press, clk, rst_n, $rose(out_tvalid), out_tuser)

endmodule

// ===== design/drktd_ram.sv =====
module drktd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/drktd_keystate.sv =====
module drktd_keystate #(
  parameter int NUM_CODES = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  drktd_pkg::item_t                   item,
  input  logic [drktd_pkg::TIME_W-1:0]       press_time,
  input  logic [drktd_pkg::TIMEOUT_W-1:0]    timeout,
  output drktd_pkg::ctl_t                    ctl,
  output logic [NUM_CODES-1:0]               key_down,
  output logic [drktd_pkg::HELD_W-1:0]       held_count
);
  import drktd_pkg::*;

  localparam int IDX_W = $clog2(NUM_CODES);
  localparam int CMP_W = KEY_W + 1;

  logic [NUM_CODES-1:0] map_valid_r, map_valid_nxt;
  logic [NUM_CODES-1:0] down_r, down_nxt;
  logic [NUM_CODES-1:0] combo_r, combo_nxt;
  logic [HELD_W-1:0]    held_r, held_nxt;
  logic [IDX_W-1:0]     idx;
  logic                 in_range;
  logic                 mapped;
  logic [TIME_W-1:0]    hold_time;
  logic                 is_tap;

  assign idx       = item.key_code[IDX_W-1:0];
  assign in_range  = {1'b0, item.key_code} < CMP_W'(NUM_CODES);
  assign mapped    = in_range && map_valid_r[idx];
  assign hold_time = item.time_ms - press_time;
  assign is_tap    = mapped && !combo_r[idx] && (hold_time < TIME_W'(timeout));

  always_comb begin
    map_valid_nxt = map_valid_r;
    down_nxt      = down_r;
    combo_nxt     = combo_r;
    held_nxt      = held_r;
    ctl           = '0;
    case (item.func)
      FUNC_PRESS: begin
        if (mapped && !down_r[idx]) begin
          down_nxt[idx] = 1'b1;
          held_nxt      = held_r + HELD_W'(1);
          ctl.pt_we     = 1'b1;
        end else if (held_r != '0) begin
          combo_nxt = down_r;
        end
      end
      FUNC_RELEASE: begin
        if (mapped) begin
          if (down_r[idx]) begin
            down_nxt[idx] = 1'b0;
            held_nxt      = held_r - HELD_W'(1);
          end
          combo_nxt[idx] = 1'b0;
          ctl.emit       = is_tap;
        end
      end
      FUNC_POINTER: begin
        if (held_r != '0) begin
          combo_nxt = down_r;
        end
      end
      FUNC_MAP_WRITE: begin
        if (in_range) begin
          map_valid_nxt[idx] = item.art_valid;
          ctl.map_we         = item.art_valid;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_valid_r <= '0;
      down_r      <= '0;
      combo_r     <= '0;
      held_r      <= '0;
    end else if (step) begin
      map_valid_r <= map_valid_nxt;
      down_r      <= down_nxt;
      combo_r     <= combo_nxt;
      held_r      <= held_nxt;
    end
  end

  assign key_down   = down_r;
  assign held_count = held_r;

endmodule

// ===== design/drktd_outq.sv =====
module drktd_outq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  drktd_pkg::pair_t              pair,
  output logic                          free,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [drktd_pkg::KEY_W-1:0]   out_tdata,
  output logic                          out_tuser,
  output logic                          out_tlast
);
  import drktd_pkg::*;

  logic             valid_r, valid_nxt;
  logic             pressed_r, pressed_nxt;
  logic [KEY_W-1:0] code_r, code_nxt;

  assign free = !valid_r || (out_tready && !pressed_r);

  always_comb begin
    valid_nxt   = valid_r;
    pressed_nxt = pressed_r;
    code_nxt    = code_r;
    if (pair.load) begin
      valid_nxt   = 1'b1;
      pressed_nxt = 1'b1;
      code_nxt    = pair.code;
    end else if (valid_r && out_tready) begin
      if (pressed_r) begin
        pressed_nxt = 1'b0;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      pressed_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      pressed_r <= pressed_nxt;
    end
    code_r <= code_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = code_r;
  assign out_tuser  = pressed_r;
  assign out_tlast  = !pressed_r;

endmodule
